### src/itt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_pkg
// Shared types and constants for the ini text tokenizer.
// ----------------------------------------------------------------------------
package itt_pkg;

    localparam int NameLimitDef  = 512;
    localparam int ValueLimitDef = 2048;
    localparam int QueueDepth    = 2;
    localparam int PosW          = 11;

    localparam logic [7:0] ChEq     = 8'h3D;
    localparam logic [7:0] ChSemi   = 8'h3B;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChUnder  = 8'h5F;
    localparam logic [7:0] ChDash   = 8'h2D;
    localparam logic [7:0] ChLbrk   = 8'h5B;
    localparam logic [7:0] ChRbrk   = 8'h5D;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChLf     = 8'h0A;

    typedef enum logic [2:0] {
        EvNone        = 3'd0,
        EvNameStart   = 3'd1,
        EvNameAppend  = 3'd2,
        EvValueStart  = 3'd3,
        EvValueAppend = 3'd4,
        EvQuotedStart = 3'd5,
        EvCommitPlain = 3'd6,
        EvCommitQuote = 3'd7
    } t_event;

    // classified beat handed from front to back
    typedef struct packed {
        logic       new_file;
        logic       parse;
        logic       is_alpha;
        logic       is_digit;
        logic       is_eq;
        logic       is_semi;
        logic       is_quote;
        logic       is_bslash;
        logic       is_blank;
        logic [7:0] ch;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

### src/itt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_front
// Accepts text beats, tracks comments and classifies each byte.
// ----------------------------------------------------------------------------
module itt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_byte_value,
    output itt_pkg::t_item    o_item
);

    logic       r_line;
    logic       r_block;
    logic [7:0] r_prev;
    logic       n_line;
    logic       n_block;
    logic [7:0] n_prev;
    logic       pass;
    logic [7:0] c;

    assign c = i_byte_value;

    always_comb begin
        n_line  = r_line;
        n_block = r_block;
        n_prev  = c;
        pass    = 1'b0;
        if (i_kind) begin
            n_line  = 1'b0;
            n_block = 1'b0;
            n_prev  = 8'h00;
        end else if (r_line) begin
            if (c == itt_pkg::ChLf || c == itt_pkg::ChCr) begin
                n_line = 1'b0;
            end
        end else if (r_block) begin
            if (r_prev == itt_pkg::ChStar && c == itt_pkg::ChSlash) begin
                n_block = 1'b0;
            end
        end else if (r_prev == itt_pkg::ChSlash && c == itt_pkg::ChSlash) begin
            n_line = 1'b1;
        end else if (r_prev == itt_pkg::ChSlash && c == itt_pkg::ChStar) begin
            n_block = 1'b1;
        end else begin
            pass = 1'b1;
        end
    end

    always_comb begin
        o_item.new_file  = i_kind;
        o_item.parse     = pass;
        o_item.is_alpha  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                           || c == itt_pkg::ChUnder || c == itt_pkg::ChDash
                           || c == itt_pkg::ChLbrk || c == itt_pkg::ChRbrk;
        o_item.is_digit  = c >= 8'h30 && c <= 8'h39;
        o_item.is_eq     = c == itt_pkg::ChEq;
        o_item.is_semi   = c == itt_pkg::ChSemi;
        o_item.is_quote  = c == itt_pkg::ChQuote;
        o_item.is_bslash = c == itt_pkg::ChBslash;
        o_item.is_blank  = c == itt_pkg::ChSpace || c == itt_pkg::ChTab
                           || c == itt_pkg::ChCr || c == itt_pkg::ChLf;
        o_item.ch        = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= 1'b0;
            r_block <= 1'b0;
            r_prev  <= 8'h00;
        end else if (i_accept) begin
            r_line  <= n_line;
            r_block <= n_block;
            r_prev  <= n_prev;
        end
    end

endmodule

### src/itt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_queue
// Short first-word-fallthrough queue between front and back.
// ----------------------------------------------------------------------------
module itt_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  itt_pkg::t_item          i_item,
    input  logic                    i_pop,
    output itt_pkg::t_item          o_item,
    output itt_pkg::t_queue_status  o_status
);

    localparam int Depth = itt_pkg::QueueDepth;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    itt_pkg::t_item  r_mem [Depth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        if (p == PtrW'(Depth - 1)) begin
            r = '0;
        end else begin
            r = p + PtrW'(1);
        end
        return r;
    endfunction

    assign o_item         = r_mem[r_rd];
    assign o_status.empty = r_count == '0;
    assign o_status.full  = r_count == CntW'(Depth);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

### src/itt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_back
// Parser state machine; turns each classified beat into one event.
// ----------------------------------------------------------------------------
module itt_back #(
    parameter int NAME_LIMIT  = itt_pkg::NameLimitDef,
    parameter int VALUE_LIMIT = itt_pkg::ValueLimitDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_pop,
    input  itt_pkg::t_item           i_item,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output itt_pkg::t_event          o_event_res,
    output logic [7:0]               o_char_out,
    output logic [itt_pkg::PosW-1:0] o_position
);

    localparam int NW   = $clog2(NAME_LIMIT);
    localparam int VW   = $clog2(VALUE_LIMIT);
    localparam int PosW = itt_pkg::PosW;

    typedef enum logic [2:0] {
        SecReady = 3'd0,
        InName   = 3'd1,
        NameEnd  = 3'd2,
        ValReady = 3'd3,
        InValue  = 3'd4,
        ValueEnd = 3'd5,
        InString = 3'd6
    } t_mode;

    t_mode           r_mode;
    logic            r_quote;
    logic            r_esc;
    logic [NW-1:0]   r_name_len;
    logic [VW-1:0]   r_val_len;
    logic            r_out_valid;
    itt_pkg::t_event r_event;
    logic [7:0]      r_char;
    logic [PosW-1:0] r_pos;

    t_mode           n_mode;
    logic            n_quote;
    logic            n_esc;
    logic [NW-1:0]   n_name_len;
    logic [VW-1:0]   n_val_len;
    itt_pkg::t_event n_event;
    logic [7:0]      n_char;
    logic [PosW-1:0] n_pos;

    logic                 tok0;
    logic                 tok1;
    logic                 name_room;
    logic                 val_room;
    logic [NW+PosW-1:0]   name_ext;
    logic [VW+PosW-1:0]   val_ext;

    assign tok0      = i_item.is_alpha;
    assign tok1      = i_item.is_alpha | i_item.is_digit;
    assign name_room = r_name_len < NW'(NAME_LIMIT - 1);
    assign val_room  = r_val_len < VW'(VALUE_LIMIT - 1);
    // positions wrap to the output width
    assign name_ext  = {{PosW{1'b0}}, r_name_len};
    assign val_ext   = {{PosW{1'b0}}, r_val_len};

    always_comb begin
        n_mode     = r_mode;
        n_quote    = r_quote;
        n_esc      = r_esc;
        n_name_len = r_name_len;
        n_val_len  = r_val_len;
        n_event    = itt_pkg::EvNone;
        n_char     = 8'h00;
        n_pos      = '0;
        if (i_item.new_file) begin
            n_mode     = SecReady;
            n_quote    = 1'b0;
            n_esc      = 1'b0;
            n_name_len = '0;
            n_val_len  = '0;
        end else if (i_item.parse) begin
            unique case (r_mode)
                SecReady: begin
                    if (tok0) begin
                        n_mode     = InName;
                        n_name_len = NW'(1);
                        n_event    = itt_pkg::EvNameStart;
                        n_char     = i_item.ch;
                    end
                end
                InName: begin
                    if (tok1) begin
                        if (name_room) begin
                            n_event    = itt_pkg::EvNameAppend;
                            n_char     = i_item.ch;
                            n_pos      = name_ext[PosW-1:0];
                            n_name_len = r_name_len + NW'(1);
                        end
                    end else if (i_item.is_eq) begin
                        n_mode = ValReady;
                    end else if (!i_item.is_blank) begin
                        n_mode = NameEnd;
                    end
                end
                NameEnd: begin
                    if (i_item.is_eq) begin
                        n_mode = ValReady;
                    end
                end
                ValReady: begin
                    if (tok1) begin
                        n_mode    = InValue;
                        n_val_len = VW'(1);
                        n_event   = itt_pkg::EvValueStart;
                        n_char    = i_item.ch;
                    end else if (i_item.is_quote) begin
                        n_mode    = InString;
                        n_quote   = 1'b1;
                        n_esc     = 1'b0;
                        n_val_len = '0;
                        n_event   = itt_pkg::EvQuotedStart;
                    end
                end
                InValue: begin
                    if (tok1) begin
                        if (val_room) begin
                            n_event   = itt_pkg::EvValueAppend;
                            n_char    = i_item.ch;
                            n_pos     = val_ext[PosW-1:0];
                            n_val_len = r_val_len + VW'(1);
                        end
                    end else if (i_item.is_semi) begin
                        n_mode  = SecReady;
                        n_event = itt_pkg::EvCommitPlain;
                    end else if (!i_item.is_blank) begin
                        n_mode = ValueEnd;
                    end
                end
                ValueEnd: begin
                    if (i_item.is_eq) begin
                        n_mode  = SecReady;
                        n_event = itt_pkg::EvCommitPlain;
                    end
                end
                InString: begin
                    priority if (!r_esc && i_item.is_quote) begin
                        n_quote = !r_quote;
                    end else if (!r_esc && i_item.is_bslash) begin
                        n_esc = 1'b1;
                    end else begin
                        // escaped byte or plain byte clears the escape mark
                        n_esc = 1'b0;
                        if (r_quote) begin
                            if (val_room) begin
                                n_event   = itt_pkg::EvValueAppend;
                                n_char    = i_item.ch;
                                n_pos     = val_ext[PosW-1:0];
                                n_val_len = r_val_len + VW'(1);
                            end
                        end else if (i_item.is_semi) begin
                            n_mode  = SecReady;
                            n_event = itt_pkg::EvCommitQuote;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= SecReady;
            r_quote     <= 1'b0;
            r_esc       <= 1'b0;
            r_name_len  <= '0;
            r_val_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop) begin
                r_mode      <= n_mode;
                r_quote     <= n_quote;
                r_esc       <= n_esc;
                r_name_len  <= n_name_len;
                r_val_len   <= n_val_len;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_event <= n_event;
            r_char  <= n_char;
            r_pos   <= n_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;
    assign o_char_out  = r_char;
    assign o_position  = r_pos;

endmodule

### src/ini_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ini_text_tokenizer
// Byte-serial tokenizer for name=value; pairs with comment and quote handling.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// input    in         i_in_valid / o_in_ready   i_kind, i_byte_value
// output   out        o_out_valid / i_out_ready o_event_res, o_char_out, o_position
//
// one beat per cycle sustained while i_out_ready stays high; every input beat yields exactly one output beat
// front classifies each beat combinationally into a two-entry queue, back parses
// the queue head into the output register
// the input stalls only when the queue is full; the output register holds
// its beat while i_out_ready is low
// synchronous active-low reset clears all parser, comment and queue state
// ----------------------------------------------------------------------------
module ini_text_tokenizer #(
    parameter int NAME_LIMIT  = itt_pkg::NameLimitDef,
    parameter int VALUE_LIMIT = itt_pkg::ValueLimitDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_kind,
    input  logic [7:0]               i_byte_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [2:0]               o_event_res,
    output logic [7:0]               o_char_out,
    output logic [itt_pkg::PosW-1:0] o_position
);

    itt_pkg::t_item         front_item;
    itt_pkg::t_item         queue_item;
    itt_pkg::t_queue_status q_status;
    itt_pkg::t_event        event_res;
    logic                   in_accept;
    logic                   pop;

    assign o_in_ready  = !q_status.full;
    assign in_accept   = i_in_valid && o_in_ready;
    assign pop         = !q_status.empty && (!o_out_valid || i_out_ready);
    assign o_event_res = event_res;

    itt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_kind       (i_kind),
        .i_byte_value (i_byte_value),
        .o_item       (front_item)
    );

    itt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    itt_back #(
        .NAME_LIMIT  (NAME_LIMIT),
        .VALUE_LIMIT (VALUE_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (pop),
        .i_item      (queue_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_event_res (event_res),
        .o_char_out  (o_char_out),
        .o_position  (o_position)
    );

    // a stalled output beat must not be overwritten by the back end
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !pop)
        else $error("back end advanced while output stalled");

    // a full queue only drains, so after a pop the next cycle cannot still be full
    a_full_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.full && pop) |=> !q_status.full)
        else $error("queue stayed full after a pop");

    // commit and quoted-start beats carry no character
    a_commit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (event_res == itt_pkg::EvCommitPlain
                         || event_res == itt_pkg::EvCommitQuote
                         || event_res == itt_pkg::EvQuotedStart))
        |-> (o_char_out == 8'h00 && o_position == '0))
        else $error("commit beat carries character data");

endmodule
